/* sv/bfid_pkg.sv */
// Shared types, constants and helper functions for the box filter downscaler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bfid_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned MAX_FACTOR  = 4;
  localparam int unsigned FACTOR_MIN  = 2;
  localparam int unsigned LINE_DEPTH  = MAX_WIDTH / FACTOR_MIN;
  localparam int unsigned ADDR_W      = $clog2(LINE_DEPTH);

  // Field widths
  localparam int unsigned DIM_W   = 13;          // configured width / height
  localparam int unsigned EXT_W   = DIM_W + 1;   // room for position + span compares
  localparam int unsigned POS_W   = 12;          // raster position
  localparam int unsigned BLK_W   = 11;          // block coordinate
  localparam int unsigned SUB_W   = 2;           // position inside a block
  localparam int unsigned FAC_W   = 3;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CH_N    = 4;
  localparam int unsigned SUM_W   = 12;          // full block sum, at most 16 * 255
  localparam int unsigned ROW_W   = 10;          // partial row sum, at most 3 * 255 + 255
  localparam int unsigned CNT_W   = 3;           // channel count register

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_W-1:0] RESET_WIDTH    = 13'd64;
  localparam logic [DIM_W-1:0] RESET_HEIGHT   = 13'd64;
  localparam logic [CNT_W-1:0] RESET_CHANNELS = 3'd4;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // floor(s / 9) = (s * RECIP9) >> RECIP_SHIFT, exact for s below 2**15
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP9      = (1 << RECIP_SHIFT) / 9 + 1;
  localparam int unsigned RECIP_W     = RECIP_SHIFT - 2;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [CH_N-1:0] pixel_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef sum_t [CH_N-1:0] sum_set_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef row_t [CH_N-1:0] row_set_t;

  // One in-block pixel, classified by the front
  typedef struct packed {
    pixel_t             pix;
    logic [BLK_W-1:0]   bx;
    logic [BLK_W-1:0]   by;
    logic               sx_first;   // first column of the block
    logic               sx_last;    // last column of the block
    logic               sy_first;   // first row of the block
    logic               sy_last;    // last row of the block
    logic               frame_last; // block is the final one of the frame
    logic [FAC_W-1:0]   factor;
  } blk_op_t;

  typedef struct packed {
    logic    valid;
    blk_op_t op;
  } q_head_t;

  // Zero reads as one, anything above the limit is clamped
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    if (v == '0) return DIM_W'(1);
    if (v > lim) return lim;
    return v;
  endfunction

  // Raise f from 2 while w/f > f and h/f > f, i.e. w >= f*(f+1)
  function automatic logic [FAC_W-1:0] pick_factor(input logic [DIM_W-1:0] w,
                                                   input logic [DIM_W-1:0] h);
    logic [FAC_W-1:0] f;
    logic             go;
    f  = FAC_W'(FACTOR_MIN);
    go = 1'b1;
    for (int unsigned i = FACTOR_MIN; i < MAX_FACTOR; i++) begin
      if (go && (w >= DIM_W'(i * (i + 1))) && (h >= DIM_W'(i * (i + 1)))) begin
        f = FAC_W'(i + 1);
      end else begin
        go = 1'b0;
      end
    end
    return f;
  endfunction

  // Channels in use: 0 or 1 -> c0, 2 -> c0 and c1, otherwise all four
  function automatic logic [CH_N-1:0] chan_mask(input logic [CNT_W-1:0] cnt);
    logic [CH_N-1:0] m;
    case (cnt) inside
      3'd0, 3'd1: m = 4'b0001;
      3'd2:       m = 4'b0011;
      default:    m = 4'b1111;
    endcase
    return m;
  endfunction

  // Truncated mean over an f-by-f block
  function automatic pix_t block_mean(input sum_t s, input logic [FAC_W-1:0] f);
    logic [PROD_W-1:0] prod;
    pix_t              m;
    prod = PROD_W'(s) * PROD_W'(RECIP9);
    case (f)
      3'd3:    m = PIX_W'(prod >> RECIP_SHIFT);
      3'd4:    m = PIX_W'(s >> 4);
      default: m = PIX_W'(s >> 2);
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/bfid_pix_if.sv */
// Pixel input channel: valid/ready handshake with four 8-bit samples.
// Depends on bfid_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfid_pix_if import bfid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_c0;
  logic [PIX_W-1:0] in_c1;
  logic [PIX_W-1:0] in_c2;
  logic [PIX_W-1:0] in_c3;

  modport source (output valid, output in_c0, output in_c1, output in_c2, output in_c3,
                  input ready);
  modport sink   (input valid, input in_c0, input in_c1, input in_c2, input in_c3,
                  output ready);
endinterface

`default_nettype wire

/* sv/bfid_blk_if.sv */
// Reduced pixel output channel: valid/ready handshake with coordinates,
// means, factor and end-of-frame flag. Depends on bfid_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfid_blk_if import bfid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] out_x;
  logic [BLK_W-1:0] out_y;
  logic [PIX_W-1:0] out_c0;
  logic [PIX_W-1:0] out_c1;
  logic [PIX_W-1:0] out_c2;
  logic [PIX_W-1:0] out_c3;
  logic [FAC_W-1:0] lod_factor;
  logic             frame_last;

  modport source (output valid, output out_x, output out_y, output out_c0, output out_c1,
                  output out_c2, output out_c3, output lod_factor, output frame_last,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_c0, input out_c1,
                  input out_c2, input out_c3, input lod_factor, input frame_last,
                  output ready);
endinterface

`default_nettype wire

/* sv/bfid_front.sv */
// Front end: tracks the raster position, picks the factor per frame and
// classifies each pixel into a block operation. Depends on bfid_pkg, bfid_pix_if.
`timescale 1ns / 1ps
`default_nettype none

module bfid_front import bfid_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic [DIM_W-1:0] width,
  input  wire logic [DIM_W-1:0] height,
  bfid_pix_if.sink              pix,
  input  wire logic             q_full,
  output logic                  push,
  output blk_op_t               push_op
);

  logic [POS_W-1:0] x, y, xs, ys;
  logic [SUB_W-1:0] x_sub, y_sub;
  logic [BLK_W-1:0] bx, by;
  logic [FAC_W-1:0] factor;

  logic [FAC_W-1:0] fac, fac_m1;
  logic [EXT_W-1:0] w_x, h_x, fac_x, xs_x, ys_x;
  logic             in_block, row_end, col_end, x_sub_last, y_sub_last, take;

  assign pix.ready = !q_full;
  assign take      = pix.valid && !q_full;

  // Classification of the current pixel
  always_comb begin
    fac        = ((x == '0) && (y == '0)) ? pick_factor(width, height) : factor;
    fac_m1     = fac - FAC_W'(1);
    w_x        = EXT_W'(width);
    h_x        = EXT_W'(height);
    fac_x      = EXT_W'(fac);
    xs_x       = EXT_W'(xs);
    ys_x       = EXT_W'(ys);
    in_block   = (w_x > fac_x) && (h_x > fac_x) &&
                 (xs_x + fac_x <= w_x) && (ys_x + fac_x <= h_x);
    row_end    = (EXT_W'(x) + EXT_W'(1)) >= w_x;
    col_end    = (EXT_W'(y) + EXT_W'(1)) >= h_x;
    x_sub_last = (FAC_W'(x_sub) == fac_m1);
    y_sub_last = (FAC_W'(y_sub) == fac_m1);

    push_op.pix        = {pix.in_c3, pix.in_c2, pix.in_c1, pix.in_c0};
    push_op.bx         = bx;
    push_op.by         = by;
    push_op.sx_first   = (x_sub == '0);
    push_op.sx_last    = x_sub_last;
    push_op.sy_first   = (y_sub == '0);
    push_op.sy_last    = y_sub_last;
    push_op.frame_last = (xs_x + (fac_x << 1) > w_x) && (ys_x + (fac_x << 1) > h_x);
    push_op.factor     = fac;
    push               = take && in_block;
  end

  // Raster position; a config write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      x     <= '0;
      y     <= '0;
      xs    <= '0;
      ys    <= '0;
      x_sub <= '0;
      y_sub <= '0;
      bx    <= '0;
      by    <= '0;
      if (rst) begin
        factor <= FAC_W'(FACTOR_MIN);
      end
    end else if (take) begin
      factor <= fac;
      if (row_end) begin
        x     <= '0;
        xs    <= '0;
        x_sub <= '0;
        bx    <= '0;
        if (col_end) begin
          y     <= '0;
          ys    <= '0;
          y_sub <= '0;
          by    <= '0;
        end else begin
          y <= y + POS_W'(1);
          if (y_sub_last) begin
            y_sub <= '0;
            ys    <= ys + POS_W'(fac);
            by    <= by + BLK_W'(1);
          end else begin
            y_sub <= y_sub + SUB_W'(1);
          end
        end
      end else begin
        x <= x + POS_W'(1);
        if (x_sub_last) begin
          x_sub <= '0;
          xs    <= xs + POS_W'(fac);
          bx    <= bx + BLK_W'(1);
        end else begin
          x_sub <= x_sub + SUB_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/bfid_queue.sv */
// Short FIFO of block operations between the front and back ends.
// Depends on bfid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfid_queue import bfid_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire blk_op_t push_op,
  output logic         full,
  output q_head_t      head,
  input  wire logic    pop
);

  blk_op_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.op    = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/bfid_back.sv */
// Back end: row accumulation, line store of block sums, mean and output
// register. Depends on bfid_pkg, bfid_blk_if.
`timescale 1ns / 1ps
`default_nettype none

module bfid_back import bfid_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire q_head_t         head,
  output logic                 pop,
  input  wire logic [CH_N-1:0] ch_mask,
  bfid_blk_if.source           blk
);

  sum_set_t         sums_mem [LINE_DEPTH];
  sum_set_t         rd_sums;
  row_set_t         row_acc;
  sum_set_t         total;
  blk_op_t          op;

  // Finished block waiting for the mean stage
  logic             b_valid;
  sum_set_t         b_sums;
  logic [BLK_W-1:0] b_x, b_y;
  logic [FAC_W-1:0] b_factor;
  logic             b_last;

  // Output register
  logic             out_valid;
  pixel_t           out_pix;
  logic [BLK_W-1:0] out_x, out_y;
  logic [FAC_W-1:0] out_factor;
  logic             out_last;

  logic             out_free, b_ready, rd_en, wr_en, emit;

  assign op       = head.op;
  assign out_free = !out_valid || blk.ready;
  assign b_ready  = !b_valid || out_free;
  assign pop      = head.valid && b_ready;
  assign rd_en    = pop && op.sx_first;
  assign wr_en    = pop && op.sx_last;
  assign emit     = pop && op.sx_last && op.sy_last;

  // Block total after this pixel: rows above + this row so far + pixel
  always_comb begin
    for (int k = 0; k < CH_N; k++) begin
      total[k] = (op.sy_first ? '0 : rd_sums[k]) + SUM_W'(row_acc[k]) + SUM_W'(op.pix[k]);
    end
  end

  // Line store read, fetched on the first column of each block row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sums <= sums_mem[op.bx];
    end
  end

  // Line store write on the last column of each block row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums_mem[op.bx] <= total;
    end
  end

  // Partial sum along the current block row
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < CH_N; k++) begin
        if (op.sx_first) begin
          row_acc[k] <= ROW_W'(op.pix[k]);
        end else begin
          row_acc[k] <= row_acc[k] + ROW_W'(op.pix[k]);
        end
      end
    end
  end

  // Finished-block stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= emit;
    end
    if (emit) begin
      b_sums   <= total;
      b_x      <= op.bx;
      b_y      <= op.by;
      b_factor <= op.factor;
      b_last   <= op.frame_last;
    end
  end

  // Mean and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= b_valid;
    end
    if (b_valid && out_free) begin
      for (int k = 0; k < CH_N; k++) begin
        out_pix[k] <= ch_mask[k] ? block_mean(b_sums[k], b_factor) : '0;
      end
      out_x      <= b_x;
      out_y      <= b_y;
      out_factor <= b_factor;
      out_last   <= b_last;
    end
  end

  assign blk.valid      = out_valid;
  assign blk.out_x      = out_x;
  assign blk.out_y      = out_y;
  assign blk.out_c0     = out_pix[0];
  assign blk.out_c1     = out_pix[1];
  assign blk.out_c2     = out_pix[2];
  assign blk.out_c3     = out_pix[3];
  assign blk.lod_factor = out_factor;
  assign blk.frame_last = out_last;

endmodule

`default_nettype wire

/* sv/box_filter_image_downscaler_top.sv */
// Top level of the box filter downscaler: configuration registers, front end,
// queue and back end. Depends on bfid_pkg, bfid_pix_if, bfid_blk_if and all bfid modules.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one raster pixel per clock while the queue is not full and returns the
// f-by-f mean of each full block (f of 2, 3 or 4, picked from the frame size at the
// first pixel) once its bottom-right pixel has passed the queue, the finished-block
// register and the output register. The rate of one pixel per cycle is set by the
// line store of block sums (2048 entries, one read on a block row's first column and
// one write on its last), which needs no clearing pass since the first row of a block
// ignores what it reads. A four-entry queue decouples pixel intake from the result
// side. Writes to the configuration registers restart the frame at column 0, row 0
// and must be made only while no block is in flight.
module box_filter_image_downscaler_top import bfid_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  bfid_pix_if.sink                   pix,
  bfid_blk_if.source                 blk
);

  logic [DIM_W-1:0] image_width, image_height;
  logic [CNT_W-1:0] channel_count;
  logic             restart;

  logic             push_valid, q_full, q_pop;
  blk_op_t          push_op;
  q_head_t          q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RESET_WIDTH;
      image_height  <= RESET_HEIGHT;
      channel_count <= RESET_CHANNELS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= DIM_W'(cfg_data);
        CFG_IMAGE_HEIGHT:  image_height  <= DIM_W'(cfg_data);
        CFG_CHANNEL_COUNT: channel_count <= CNT_W'(cfg_data);
        default:           ;
      endcase
    end
  end

  // Any known register write restarts the frame position
  assign restart = cfg_write && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                 (cfg_index == CFG_IMAGE_HEIGHT) ||
                                 (cfg_index == CFG_CHANNEL_COUNT));

  bfid_front u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .width   (eff_dim(image_width, DIM_W'(MAX_WIDTH))),
    .height  (eff_dim(image_height, DIM_W'(MAX_HEIGHT))),
    .pix     (pix),
    .q_full  (q_full),
    .push    (push_valid),
    .push_op (push_op)
  );

  bfid_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push_valid),
    .push_op (push_op),
    .full    (q_full),
    .head    (q_head),
    .pop     (q_pop)
  );

  bfid_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .pop     (q_pop),
    .ch_mask (chan_mask(channel_count)),
    .blk     (blk)
  );

  // Front never writes into a full queue
  assert property (@(posedge clk) disable iff (rst) push_valid |-> !q_full)
    else $error("block operation pushed into a full queue");

  // Back never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_head.valid)
    else $error("pop from an empty queue");

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !blk.valid)
    else $error("result valid right after reset");

  // Reported factor stays in its legal range
  assert property (@(posedge clk) disable iff (rst)
      blk.valid |-> ((blk.lod_factor >= FAC_W'(FACTOR_MIN)) &&
                     (blk.lod_factor <= FAC_W'(MAX_FACTOR))))
    else $error("factor out of range on a result");

endmodule

`default_nettype wire

/* dv/box_filter_image_downscaler_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for box_filter_image_downscaler_top: streams raster pixels under
// several frame configurations and checks each reduced pixel against a built-in predictor.
// Depends on bfid_pkg, bfid_pix_if, bfid_blk_if and the RTL of the downscaler.

module box_filter_image_downscaler_top_test;
  import bfid_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 32;
  localparam int unsigned LONG_STALL    = 400;
  localparam int unsigned RANDOM_PIXELS = 320;
  localparam int unsigned CALM_AFTER    = 240;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO} fill_t;

  typedef struct packed {
    logic [BLK_W-1:0] x;
    logic [BLK_W-1:0] y;
    pix_t             c0;
    pix_t             c1;
    pix_t             c2;
    pix_t             c3;
    logic [FAC_W-1:0] factor;
    logic             last;
  } reduced_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfid_pix_if pix_ch();
  bfid_blk_if blk_ch();

  box_filter_image_downscaler_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .blk       (blk_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: registers, raster position, factor and the line of block sums
  logic [DIM_W-1:0] img_w    = RESET_WIDTH;
  logic [DIM_W-1:0] img_h    = RESET_HEIGHT;
  logic [CNT_W-1:0] chan_cfg = RESET_CHANNELS;
  logic [POS_W-1:0] col_pos  = '0;
  logic [POS_W-1:0] row_pos  = '0;
  logic [FAC_W-1:0] lod      = FAC_W'(FACTOR_MIN);
  sum_t             block_acc [LINE_DEPTH][CH_N];

  reduced_t    expected_blocks[$];
  pixel_t      pending_pixels[$];
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned idle_pct      = 0;
  int unsigned stall_asks    = 0;
  int unsigned stalls_granted = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;

  // Advance one raster pixel; queue the block mean when it closes a block
  function automatic void account_pixel(input pixel_t px);
    int unsigned w, h, x, y, f, bx, by, bw, bh, nch, s;
    bit          is_first, is_last;
    pix_t        means [CH_N];
    reduced_t    r;
    w = (img_w == 0) ? 1 : (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
    h = (img_h == 0) ? 1 : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
    x = col_pos;
    y = row_pos;
    // factor is chosen at the top-left pixel of each frame
    if (x == 0 && y == 0) begin
      f = FACTOR_MIN;
      while (w / f > f && h / f > f && f < MAX_FACTOR) f++;
      lod = FAC_W'(f);
    end
    f  = lod;
    bw = w / f;
    bh = h / f;
    bx = x / f;
    by = y / f;
    if (w > f && h > f && bx < bw && by < bh && bx < LINE_DEPTH) begin
      is_first = (x % f == 0) && (y % f == 0);
      is_last  = (x % f == f - 1) && (y % f == f - 1);
      for (int k = 0; k < CH_N; k++) begin
        s = px[k];
        if (!is_first) s += block_acc[bx][k];
        block_acc[bx][k] = SUM_W'(s);
      end
      if (is_last) begin
        nch = (chan_cfg == 0) ? 1 : (chan_cfg >= 3) ? CH_N : chan_cfg;
        for (int k = 0; k < CH_N; k++)
          means[k] = (k < nch) ? PIX_W'(block_acc[bx][k] / (f * f)) : '0;
        r.x      = BLK_W'(bx);
        r.y      = BLK_W'(by);
        r.c0     = means[0];
        r.c1     = means[1];
        r.c2     = means[2];
        r.c3     = means[3];
        r.factor = FAC_W'(f);
        r.last   = (bx == bw - 1) && (by == bh - 1);
        expected_blocks.insert(expected_blocks.size(), r);
      end
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = POS_W'(x);
    row_pos = POS_W'(y);
  endfunction

  function automatic void check_field(input string name, input logic [BLK_W-1:0] want_v,
                                      input logic [BLK_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // One register write per edge; the predictor takes it at once since nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_IMAGE_WIDTH:   img_w = val;
      CFG_IMAGE_HEIGHT:  img_h = val;
      CFG_CHANNEL_COUNT: chan_cfg = val[CNT_W-1:0];
      default:           return;
    endcase
    // any real register write restarts the frame
    col_pos = '0;
    row_pos = '0;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic setup_frame(input int unsigned w, input int unsigned h, input int unsigned ch);
    logic [CFG_DATA_W-1:0] ch_word;
    ch_word = CFG_DATA_W'($urandom);
    ch_word[CNT_W-1:0] = CNT_W'(ch);
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_CHANNEL_COUNT, ch_word);
    end_writes();
  endtask

  task automatic queue_pixels(input int unsigned n, input fill_t mode);
    pixel_t p;
    repeat (n) begin
      case (mode)
        FILL_MAX:  p = '1;
        FILL_ZERO: p = '0;
        default:   p = pixel_t'($urandom);
      endcase
      pending_pixels.insert(pending_pixels.size(), p);
      pixels_queued++;
    end
  endtask

  // Wait for every queued pixel and every expected result, then let the pipeline drain
  task automatic settle();
    do @(posedge clk);
    while (pixels_taken != pixels_queued || expected_blocks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned ch,
                           input int unsigned n, input fill_t mode);
    setup_frame(w, h, ch);
    queue_pixels(n, mode);
    settle();
  endtask

  // Pixel driver: next item only after the current one is transferred
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (send_gap == 0 && pending_pixels.size() != 0 && idle_pct != 0 &&
          $urandom_range(0, 99) < idle_pct)
        send_gap = $urandom_range(1, 13);
      if (send_gap != 0) begin
        send_gap--;
        pix_ch.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        p = pending_pixels.pop_front();
        pix_ch.in_c0 <= p[0];
        pix_ch.in_c1 <= p[1];
        pix_ch.in_c2 <= p[2];
        pix_ch.in_c3 <= p[3];
        pix_ch.valid <= 1'b1;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Result side ready: random bursts plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      blk_ch.ready <= 1'b0;
    end else begin
      if (recv_stall == 0) begin
        if (stalls_granted != stall_asks) begin
          stalls_granted++;
          recv_stall = LONG_STALL;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          recv_stall = $urandom_range(1, 13);
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        blk_ch.ready <= 1'b0;
      end else begin
        blk_ch.ready <= 1'b1;
      end
    end
  end

  // Input monitor: each pixel transfer steps the predictor
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      account_pixel({pix_ch.in_c3, pix_ch.in_c2, pix_ch.in_c1, pix_ch.in_c0});
      pixels_taken++;
    end
  end

  // Output monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    reduced_t want;
    if (!rst && blk_ch.valid && blk_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual (%0d,%0d)", $time,
                 blk_ch.out_x, blk_ch.out_y);
        mismatches++;
      end else begin
        want = expected_blocks.pop_front();
        check_field("out_x", want.x, blk_ch.out_x);
        check_field("out_y", want.y, blk_ch.out_y);
        check_field("out_c0", want.c0, blk_ch.out_c0);
        check_field("out_c1", want.c1, blk_ch.out_c1);
        check_field("out_c2", want.c2, blk_ch.out_c2);
        check_field("out_c3", want.c3, blk_ch.out_c3);
        check_field("lod_factor", want.factor, blk_ch.lod_factor);
        check_field("frame_last", want.last, blk_ch.frame_last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL box_filter_image_downscaler_top");
      $finish;
    end
  end

  initial begin
    int unsigned w, h, n, random_sent;
    pix_ch.valid = 1'b0;
    pix_ch.in_c0 = '0;
    pix_ch.in_c1 = '0;
    pix_ch.in_c2 = '0;
    pix_ch.in_c3 = '0;
    blk_ch.ready = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Saturated 2x2 blocks, then part of a bottom row that is dropped
    idle_pct = 0;
    run_phase(4, 3, 4, 10, FILL_MAX);
    // One block with a dropped right column, two channels, all-zero samples
    idle_pct = 20;
    run_phase(3, 3, 2, 9, FILL_ZERO);
    // Frame no wider than the factor: nothing comes out
    run_phase(2, 8, 1, 2, FILL_RANDOM);
    // Zero width and height read as one
    run_phase(0, 0, 0, 2, FILL_RANDOM);
    // Oversize width is clamped; only the first row is fed
    run_phase(8191, 13, 3, 2, FILL_RANDOM);
    // Oversize height is clamped; factor stays 2 on a four-wide frame
    run_phase(4, 8191, 7, 8, FILL_MAX);

    // Long hold-off on the result side while pixels keep coming: queue fills, input stalls
    idle_pct = 0;
    setup_frame(8, 8, 4);
    stall_asks++;
    queue_pixels(128, FILL_RANDOM);
    settle();

    // Wide line: a long row of blocks with a dropped right column and bottom row
    idle_pct = 3;
    run_phase(131, 3, $urandom_range(0, 7), 2 * 131 + 8, FILL_RANDOM);

    // Random frames, mostly whole; the last stretch runs with no idling
    random_sent = 0;
    w = 1;
    h = 1;
    while (random_sent < RANDOM_PIXELS) begin
      idle_pct = (random_sent >= CALM_AFTER) ? 0 : $urandom_range(0, 3) * 10;
      if (random_sent != 0 && $urandom_range(0, 5) == 0) begin
        // unknown index: the frame position must carry on
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        end_writes();
        n = $urandom_range(1, w * h);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          w = $urandom_range(12, 20);
          h = $urandom_range(12, 20);
        end else begin
          w = $urandom_range(1, 14);
          h = $urandom_range(1, 14);
        end
        case ($urandom_range(0, 9))
          0, 1, 2: n = $urandom_range(1, w * h);
          3:       n = 2 * w * h;
          default: n = w * h;
        endcase
        setup_frame(w, h, $urandom_range(0, 7));
      end
      // keep the total close to the planned pixel count
      if (n > RANDOM_PIXELS - random_sent) n = RANDOM_PIXELS - random_sent;
      queue_pixels(n, FILL_RANDOM);
      settle();
      random_sent += n;
    end

    if (mismatches == 0)
      $display("PASS box_filter_image_downscaler_top");
    else
      $display("FAIL box_filter_image_downscaler_top");
    $finish;
  end

endmodule
